@@ sv/fba_pkg.sv @@
// Shared constants for the file block allocator.
`timescale 1ns / 1ps
`default_nettype none
package fba_pkg;
  // Default geometry
  localparam int BLOCK_BYTES_DEF     = 512;
  localparam int NUM_BLOCKS_DEF      = 2048;
  localparam int FILE_SLOTS_DEF      = 64;
  localparam int BLOCKS_PER_FILE_DEF = 10;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int OFFSET_W = 13;
  localparam int DATA_W   = 8;
  localparam int STAT_W   = 2;
  localparam int MAP_W    = 16;  // bits per bitmap word
  localparam int MAP_BW   = 4;   // log2 of MAP_W

  // Commands
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK = 2'd2;
  localparam logic [STAT_W-1:0] ST_END      = 2'd3;
endpackage
`default_nettype wire

@@ sv/fba_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/file_block_allocator.sv @@
// Top level: command sequencer around the pointer, bitmap and byte memories.
//
// Usage: one command per input transfer on in_valid/in_ready (command, slot,
// offset, data_in); exactly one result per command on out_valid/out_ready
// (status, slot_out, data_out, block_out), in command order.
// Steps per command, from acceptance to result ready:
//   write/read with an end condition or delete of an unused slot: straight to the result
//   write through a filled pointer: pointer read, byte write; read: pointer read, byte read
//   write that allocates: pointer read, then a scan of bitmap words (16 blocks a word)
//   create: a slot scan, then BLOCKS_PER_FILE pointer clears
//   delete: a read and clear of each pointer, and a bitmap update per filled pointer
// Commands are handled one at a time. After reset a clearing pass empties
// all pointers and frees all blocks; in_ready stays low during it. A
// finished result sits in the output register until taken; a stalled
// receiver holds the sequencer at the result step, and no new command is
// accepted until the result moves.
`timescale 1ns / 1ps
`default_nettype none
module file_block_allocator #(
  parameter int BLOCK_BYTES     = fba_pkg::BLOCK_BYTES_DEF,
  parameter int NUM_BLOCKS      = fba_pkg::NUM_BLOCKS_DEF,
  parameter int FILE_SLOTS      = fba_pkg::FILE_SLOTS_DEF,
  parameter int BLOCKS_PER_FILE = fba_pkg::BLOCKS_PER_FILE_DEF,
  parameter int SLOT_W          = $clog2(FILE_SLOTS),
  parameter int BW              = $clog2(NUM_BLOCKS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fba_pkg::CMD_W-1:0]     command,
  input  wire logic [SLOT_W-1:0]             slot,
  input  wire logic [fba_pkg::OFFSET_W-1:0]  offset,
  input  wire logic [fba_pkg::DATA_W-1:0]    data_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [fba_pkg::STAT_W-1:0]    status,
  output logic      [SLOT_W-1:0]             slot_out,
  output logic      [fba_pkg::DATA_W-1:0]    data_out,
  output logic      [BW-1:0]                 block_out
);
  import fba_pkg::*;

  localparam int BB_W   = $clog2(BLOCK_BYTES);
  localparam int PI_W   = OFFSET_W - BB_W;
  localparam int PTRS   = FILE_SLOTS * BLOCKS_PER_FILE;
  localparam int PA_W   = (PTRS > 1) ? $clog2(PTRS) : 1;
  localparam int NW     = NUM_BLOCKS / MAP_W;
  localparam int WW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int CLR_N  = (PTRS > NW) ? PTRS : NW;
  localparam int CW     = $clog2(CLR_N + 1);
  localparam int JW     = $clog2(BLOCKS_PER_FILE + 1);
  localparam int SCW    = $clog2(FILE_SLOTS + 1);
  localparam int BA_W   = BW + BB_W;
  localparam int STORE  = NUM_BLOCKS * BLOCK_BYTES;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CSCAN = 4'd2;
  localparam logic [3:0] S_CCLR  = 4'd3;
  localparam logic [3:0] S_DRD   = 4'd4;
  localparam logic [3:0] S_DCHK  = 4'd5;
  localparam logic [3:0] S_DMAP  = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;
  localparam logic [3:0] S_PCHK  = 4'd8;
  localparam logic [3:0] S_BWAIT = 4'd9;
  localparam logic [3:0] S_ASCAN = 4'd10;
  localparam logic [3:0] S_AWAIT = 4'd11;
  localparam logic [3:0] S_RESP  = 4'd12;

  logic [3:0]            state;
  logic [CW-1:0]         clr_cnt;
  logic [FILE_SLOTS-1:0] slot_used;
  logic [CMD_W-1:0]      cmd;
  logic [SLOT_W-1:0]     cur_slot;
  logic [BB_W-1:0]       byte_off;
  logic [DATA_W-1:0]     wdata;
  logic [PA_W-1:0]       paddr;
  logic [JW-1:0]         j;
  logic [SCW-1:0]        scan;
  logic [WW-1:0]         wcnt;
  logic [BW-1:0]         blk;
  logic [STAT_W-1:0]     res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [DATA_W-1:0]     res_data;
  logic [BW-1:0]         res_block;

  // Memory ports
  logic                  ptr_we;
  logic [PA_W-1:0]       ptr_waddr;
  logic [BW:0]           ptr_wdata;
  logic [BW:0]           ptr_rdata;
  logic                  map_we;
  logic [WW-1:0]         map_waddr;
  logic [MAP_W-1:0]      map_wdata;
  logic [WW-1:0]         map_raddr;
  logic [MAP_W-1:0]      map_rdata;
  logic                  byte_we;
  logic [BW-1:0]         byte_blk;
  logic [DATA_W-1:0]     byte_rdata;

  // Decode of the incoming command
  logic [PI_W-1:0]       in_pidx;
  logic                  in_slot_ok;
  logic                  in_pidx_ok;
  logic [PA_W-1:0]       in_paddr;

  // Lowest free bit of the bitmap word
  logic                  zfound;
  logic [MAP_BW-1:0]     zbit;
  logic [BW-1:0]         new_blk;
  logic                  ptr_valid;
  logic [BW-1:0]         ptr_blk;

  assign in_ready  = (state == S_IDLE);
  assign in_pidx   = offset[OFFSET_W-1:BB_W];
  assign in_slot_ok = (32'(slot) < FILE_SLOTS) && slot_used[slot];
  assign in_pidx_ok = (32'(in_pidx) < BLOCKS_PER_FILE);
  assign in_paddr  = PA_W'(PA_W'(slot) * PA_W'(BLOCKS_PER_FILE)) + PA_W'(in_pidx);
  assign ptr_valid = ptr_rdata[BW];
  assign ptr_blk   = ptr_rdata[BW-1:0];
  assign new_blk   = BW'({wcnt, zbit});

  always_comb begin
    zfound = 1'b0;
    zbit   = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!map_rdata[i]) begin
        zfound = 1'b1;
        zbit   = MAP_BW'(i);
      end
    end
  end

  // Memory port steering
  always_comb begin
    ptr_we    = 1'b0;
    ptr_waddr = paddr;
    ptr_wdata = '0;
    map_we    = 1'b0;
    map_waddr = wcnt;
    map_wdata = '0;
    map_raddr = wcnt;
    byte_we   = 1'b0;
    byte_blk  = ptr_blk;
    unique case (state)
      S_CLR: begin
        ptr_we    = (32'(clr_cnt) < PTRS);
        ptr_waddr = clr_cnt[PA_W-1:0];
        map_we    = (32'(clr_cnt) < NW);
        map_waddr = clr_cnt[WW-1:0];
      end
      S_CCLR: ptr_we = 1'b1;
      S_DCHK: begin
        ptr_we    = 1'b1;
        map_raddr = WW'(ptr_blk >> MAP_BW);
      end
      S_DMAP: begin
        map_we    = 1'b1;
        map_waddr = WW'(blk >> MAP_BW);
        map_wdata = map_rdata & ~(MAP_W'(1) << blk[MAP_BW-1:0]);
      end
      S_PCHK: byte_we = (cmd == CMD_WRITE) && ptr_valid;
      S_AWAIT: begin
        if (zfound) begin
          ptr_we    = 1'b1;
          ptr_wdata = {1'b1, new_blk};
          map_we    = 1'b1;
          map_wdata = map_rdata | (MAP_W'(1) << zbit);
          byte_we   = 1'b1;
          byte_blk  = new_blk;
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      slot_used <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == CLR_N - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            cur_slot   <= slot;
            byte_off   <= offset[BB_W-1:0];
            wdata      <= data_in;
            paddr      <= (command == CMD_DELETE) ?
                          PA_W'(PA_W'(slot) * PA_W'(BLOCKS_PER_FILE)) : in_paddr;
            j          <= '0;
            scan       <= '0;
            wcnt       <= '0;
            res_slot   <= '0;
            res_data   <= '0;
            res_block  <= '0;
            unique case (command)
              CMD_CREATE: begin
                res_status <= ST_OK;
                state      <= S_CSCAN;
              end
              CMD_DELETE: begin
                res_status <= ST_OK;
                state      <= in_slot_ok ? S_DRD : S_RESP;
              end
              default: begin
                if (in_slot_ok && in_pidx_ok) begin
                  res_status <= ST_OK;
                  state      <= S_PRD;
                end else begin
                  res_status <= ST_END;
                  state      <= S_RESP;
                end
              end
            endcase
          end
        end
        // find the lowest unused slot
        S_CSCAN: begin
          if (!slot_used[SLOT_W'(scan)]) begin
            slot_used[SLOT_W'(scan)] <= 1'b1;
            res_slot <= SLOT_W'(scan);
            paddr    <= PA_W'(PA_W'(scan) * PA_W'(BLOCKS_PER_FILE));
            state    <= S_CCLR;
          end else if (32'(scan) == FILE_SLOTS - 1) begin
            res_status <= ST_NO_SLOT;
            state      <= S_RESP;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        // empty the new slot's pointers
        S_CCLR: begin
          paddr <= paddr + 1'b1;
          j     <= j + 1'b1;
          if (32'(j) == BLOCKS_PER_FILE - 1) begin
            state <= S_RESP;
          end
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          blk <= ptr_blk;
          if (ptr_valid) begin
            state <= S_DMAP;
          end else if (32'(j) == BLOCKS_PER_FILE - 1) begin
            slot_used[cur_slot] <= 1'b0;
            state <= S_RESP;
          end else begin
            j     <= j + 1'b1;
            paddr <= paddr + 1'b1;
            state <= S_DRD;
          end
        end
        S_DMAP: begin
          if (32'(j) == BLOCKS_PER_FILE - 1) begin
            slot_used[cur_slot] <= 1'b0;
            state <= S_RESP;
          end else begin
            j     <= j + 1'b1;
            paddr <= paddr + 1'b1;
            state <= S_DRD;
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (ptr_valid) begin
            res_block <= ptr_blk;
            state     <= (cmd == CMD_READ) ? S_BWAIT : S_RESP;
          end else if (cmd == CMD_READ) begin
            res_status <= ST_END;
            state      <= S_RESP;
          end else begin
            state <= S_ASCAN;
          end
        end
        S_BWAIT: begin
          res_data <= byte_rdata;
          state    <= S_RESP;
        end
        S_ASCAN: state <= S_AWAIT;
        // take the lowest free block in this word, or move on
        S_AWAIT: begin
          if (zfound) begin
            res_block <= new_blk;
            state     <= S_RESP;
          end else if (32'(wcnt) == NW - 1) begin
            res_status <= ST_NO_BLOCK;
            state      <= S_RESP;
          end else begin
            wcnt  <= wcnt + 1'b1;
            state <= S_ASCAN;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            slot_out  <= res_slot;
            data_out  <= res_data;
            block_out <= res_block;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fba_ram #(.WIDTH(BW + 1), .DEPTH(PTRS), .AW(PA_W)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .raddr (paddr),
    .rdata (ptr_rdata)
  );

  fba_ram #(.WIDTH(MAP_W), .DEPTH(NW), .AW(WW)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  fba_ram #(.WIDTH(DATA_W), .DEPTH(STORE), .AW(BA_W)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr ({byte_blk, byte_off}),
    .wdata (wdata),
    .raddr ({ptr_blk, byte_off}),
    .rdata (byte_rdata)
  );
endmodule
`default_nettype wire
